FILE: hdl/sbc_pkg.sv
`timescale 1ns / 1ps

package sbc_pkg;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int DIMENSIONS  = 3;
    localparam int LANES       = 3;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int SQ_W    = 2 * CROSS_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int NUM_W   = 2 * CROSS_W - 2;
    localparam int WEIGHT_W = 25;
    localparam int LIM_W   = NUM_W + 2 * FRAC_BITS;
    localparam int U_W     = NUM_W + WEIGHT_W;
    localparam int CAND_W  = U_W + WEIGHT_W + 1;

    localparam int ROOT_STAGES = WEIGHT_W;
    localparam int FRONT_STAGES = 5;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic [DIMENSIONS-1:0][COORD_BITS-1:0]            pnt;
        logic [LANES-1:0][DIMENSIONS-1:0][COORD_BITS-1:0] vtx;
    } coord_item_t;

    typedef struct packed {
        logic [NUM_W-1:0]            den;
        logic [LANES-1:0][NUM_W-1:0] num;
        logic [LANES-1:0]            neg;
        logic                        degen;
    } area_item_t;

    typedef struct packed {
        logic [LANES-1:0][WEIGHT_W-1:0] weight;
        logic                           degen;
    } weight_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic int nxt(input int k);
        return (k + 1) % DIMENSIONS;
    endfunction

    function automatic int prv(input int k);
        return (k + 2) % DIMENSIONS;
    endfunction

endpackage

FILE: hdl/sbc_front.sv
`timescale 1ns / 1ps

module sbc_front
    import sbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  coord_item_t in_item,
    input  logic        q_full,
    output logic        ready,
    output logic        out_valid,
    output area_item_t  out_item
);

    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] vld_next;
    logic                    adv;

    logic signed [DIFF_W-1:0]  f_reg   [LANES][DIMENSIONS];
    logic signed [DIFF_W-1:0]  e1_reg  [DIMENSIONS];
    logic signed [DIFF_W-1:0]  e2_reg  [DIMENSIONS];
    logic signed [PROD_W-1:0]  pp_reg  [4][DIMENSIONS][2];
    logic signed [CROSS_W-1:0] cr_reg  [4][DIMENSIONS];
    logic signed [SQ_W-1:0]    sq_reg  [4][DIMENSIONS];
    logic signed [SQ_W-1:0]    dot_reg [LANES][DIMENSIONS];
    area_item_t                item_reg;

    logic signed [DIFF_W-1:0]  f_next   [LANES][DIMENSIONS];
    logic signed [DIFF_W-1:0]  e1_next  [DIMENSIONS];
    logic signed [DIFF_W-1:0]  e2_next  [DIMENSIONS];
    logic signed [PROD_W-1:0]  pp_next  [4][DIMENSIONS][2];
    logic signed [CROSS_W-1:0] cr_next  [4][DIMENSIONS];
    logic signed [SQ_W-1:0]    sq_next  [4][DIMENSIONS];
    logic signed [SQ_W-1:0]    dot_next [LANES][DIMENSIONS];
    area_item_t                item_next;

    logic signed [DIFF_W-1:0] opa [4][DIMENSIONS];
    logic signed [DIFF_W-1:0] opb [4][DIMENSIONS];
    logic signed [SUM_W-1:0]  acc [4];
    logic signed [SUM_W-1:0]  dacc [LANES];

    assign adv       = !(vld_reg[FRONT_STAGES-1] && q_full);
    assign ready     = adv;
    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign out_item  = item_reg;

    always_comb
    begin
        vld_next = {vld_reg[FRONT_STAGES-2:0], in_valid};
        for (int k = 0; k < DIMENSIONS; k++)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                f_next[i][k] = DIFF_W'($signed(in_item.vtx[i][k]))
                             - DIFF_W'($signed(in_item.pnt[k]));
            end
            e1_next[k] = DIFF_W'($signed(in_item.vtx[0][k]))
                       - DIFF_W'($signed(in_item.vtx[1][k]));
            e2_next[k] = DIFF_W'($signed(in_item.vtx[0][k]))
                       - DIFF_W'($signed(in_item.vtx[2][k]));
        end

        // triangle normal, then sub-areas opposite each vertex
        for (int k = 0; k < DIMENSIONS; k++)
        begin
            opa[0][k] = e1_reg[k];
            opb[0][k] = e2_reg[k];
            opa[1][k] = f_reg[1][k];
            opb[1][k] = f_reg[2][k];
            opa[2][k] = f_reg[2][k];
            opb[2][k] = f_reg[0][k];
            opa[3][k] = f_reg[0][k];
            opb[3][k] = f_reg[1][k];
        end

        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < DIMENSIONS; k++)
            begin
                pp_next[c][k][0] = PROD_W'(opa[c][nxt(k)]) * PROD_W'(opb[c][prv(k)]);
                pp_next[c][k][1] = PROD_W'(opa[c][prv(k)]) * PROD_W'(opb[c][nxt(k)]);
                cr_next[c][k] = CROSS_W'(pp_reg[c][k][0]) - CROSS_W'(pp_reg[c][k][1]);
                sq_next[c][k] = SQ_W'(cr_reg[c][k]) * SQ_W'(cr_reg[c][k]);
            end
        end

        for (int i = 0; i < LANES; i++)
        begin
            for (int k = 0; k < DIMENSIONS; k++)
            begin
                dot_next[i][k] = SQ_W'(cr_reg[0][k]) * SQ_W'(cr_reg[i + 1][k]);
            end
        end

        for (int c = 0; c < 4; c++)
        begin
            acc[c] = SUM_W'(sq_reg[c][0]) + SUM_W'(sq_reg[c][1]) + SUM_W'(sq_reg[c][2]);
        end
        for (int i = 0; i < LANES; i++)
        begin
            dacc[i] = SUM_W'(dot_reg[i][0]) + SUM_W'(dot_reg[i][1])
                    + SUM_W'(dot_reg[i][2]);
        end

        item_next.den   = acc[0][NUM_W-1:0];
        item_next.degen = (acc[0] == '0);
        for (int i = 0; i < LANES; i++)
        begin
            item_next.num[i] = acc[i + 1][NUM_W-1:0];
            item_next.neg[i] = dacc[i][SUM_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_reg    <= f_next;
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
            pp_reg   <= pp_next;
            cr_reg   <= cr_next;
            sq_reg   <= sq_next;
            dot_reg  <= dot_next;
            item_reg <= item_next;
        end
    end

endmodule

FILE: hdl/sbc_mid_queue.sv
`timescale 1ns / 1ps

module sbc_mid_queue
    import sbc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  area_item_t    wr_item,
    input  logic          rd_en,
    output area_item_t    rd_item,
    output queue_status_t status
);

    area_item_t     mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   cnt_reg;
    logic [QAW:0]   cnt_next;

    assign rd_item      = mem_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == (QAW + 1)'(QDEPTH));
    assign status.empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

FILE: hdl/sbc_back.sv
`timescale 1ns / 1ps

module sbc_back
    import sbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  area_item_t   in_item,
    input  logic         out_full,
    output logic         take,
    output logic         out_valid,
    output weight_item_t out_item
);

    logic [ROOT_STAGES-1:0] vld_reg;
    logic                   adv;

    logic [LIM_W-1:0]    t_reg     [ROOT_STAGES][LANES];
    logic [U_W-1:0]      u_reg     [ROOT_STAGES][LANES];
    logic [WEIGHT_W-1:0] m_reg     [ROOT_STAGES][LANES];
    logic [LIM_W-1:0]    lim_reg   [ROOT_STAGES][LANES];
    logic [NUM_W-1:0]    den_reg   [ROOT_STAGES];
    logic [LANES-1:0]    neg_reg   [ROOT_STAGES];
    logic                degen_reg [ROOT_STAGES];

    assign adv  = !(vld_reg[ROOT_STAGES-1] && out_full);
    assign take = adv && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[ROOT_STAGES-2:0], in_valid};
        end
    end

    for (genvar s = 0; s < ROOT_STAGES; s++)
    begin : g_stage
        localparam int BIT = ROOT_STAGES - 1 - s;

        logic [LIM_W-1:0]    t_in   [LANES];
        logic [U_W-1:0]      u_in   [LANES];
        logic [WEIGHT_W-1:0] m_in   [LANES];
        logic [LIM_W-1:0]    lim_in [LANES];
        logic [NUM_W-1:0]    den_in;
        logic [LANES-1:0]    neg_in;
        logic                degen_in;
        logic [CAND_W-1:0]   cand   [LANES];
        logic                hit    [LANES];

        if (s == 0)
        begin : g_head
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    t_in[l]   = '0;
                    u_in[l]   = '0;
                    m_in[l]   = '0;
                    lim_in[l] = {in_item.num[l], (2 * FRAC_BITS)'(0)};
                end
                den_in   = in_item.den;
                neg_in   = in_item.neg;
                degen_in = in_item.degen;
            end
        end
        else
        begin : g_body
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    t_in[l]   = t_reg[s-1][l];
                    u_in[l]   = u_reg[s-1][l];
                    m_in[l]   = m_reg[s-1][l];
                    lim_in[l] = lim_reg[s-1][l];
                end
                den_in   = den_reg[s-1];
                neg_in   = neg_reg[s-1];
                degen_in = degen_reg[s-1];
            end
        end

        // (m + 2^b)^2 * den from m^2 * den and m * den
        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                cand[l] = CAND_W'(t_in[l]) + (CAND_W'(u_in[l]) << (BIT + 1))
                        + (CAND_W'(den_in) << (2 * BIT));
                hit[l]  = (cand[l] <= CAND_W'(lim_in[l]))
                        && !((s != 0) && m_in[l][WEIGHT_W-1]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    t_reg[s][l]   <= hit[l] ? cand[l][LIM_W-1:0] : t_in[l];
                    u_reg[s][l]   <= hit[l] ? u_in[l] + (U_W'(den_in) << BIT) : u_in[l];
                    m_reg[s][l]   <= hit[l] ? m_in[l] | (WEIGHT_W'(1) << BIT) : m_in[l];
                    lim_reg[s][l] <= lim_in[l];
                end
                den_reg[s]   <= den_in;
                neg_reg[s]   <= neg_in;
                degen_reg[s] <= degen_in;
            end
        end
    end

    always_comb
    begin
        out_valid      = vld_reg[ROOT_STAGES-1];
        out_item.degen = degen_reg[ROOT_STAGES-1];
        for (int l = 0; l < LANES; l++)
        begin
            if (degen_reg[ROOT_STAGES-1])
            begin
                out_item.weight[l] = '0;
            end
            else if (neg_reg[ROOT_STAGES-1][l])
            begin
                out_item.weight[l] = -m_reg[ROOT_STAGES-1][l];
            end
            else if (m_reg[ROOT_STAGES-1][l][WEIGHT_W-1])
            begin
                out_item.weight[l] = {1'b0, {(WEIGHT_W - 1){1'b1}}};
            end
            else
            begin
                out_item.weight[l] = m_reg[ROOT_STAGES-1][l];
            end
        end
    end

endmodule

FILE: hdl/sbc_out_queue.sv
`timescale 1ns / 1ps

module sbc_out_queue
    import sbc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  weight_item_t  wr_item,
    input  logic          rd_en,
    output weight_item_t  rd_item,
    output queue_status_t status
);

    weight_item_t   mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   cnt_reg;
    logic [QAW:0]   cnt_next;

    assign rd_item      = mem_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == (QAW + 1)'(QDEPTH));
    assign status.empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

FILE: hdl/signed_barycentric_3d_unit.sv
// throughput: one beat per cycle while full is low, through the 5-stage front and 25-stage root pipeline
// two 4-entry queues, front-to-back and at the output, absorb stalls on either side
// reset: asynchronous active-low rst_n empties both queues and clears pipeline valids
`timescale 1ns / 1ps

module signed_barycentric_3d_unit
    import sbc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [COORD_BITS-1:0]      point_x,
    input  logic [COORD_BITS-1:0]      point_y,
    input  logic [COORD_BITS-1:0]      point_z,
    input  logic [COORD_BITS-1:0]      vertex0_x,
    input  logic [COORD_BITS-1:0]      vertex0_y,
    input  logic [COORD_BITS-1:0]      vertex0_z,
    input  logic [COORD_BITS-1:0]      vertex1_x,
    input  logic [COORD_BITS-1:0]      vertex1_y,
    input  logic [COORD_BITS-1:0]      vertex1_z,
    input  logic [COORD_BITS-1:0]      vertex2_x,
    input  logic [COORD_BITS-1:0]      vertex2_y,
    input  logic [COORD_BITS-1:0]      vertex2_z,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [WEIGHT_W-1:0] weight_first,
    output logic signed [WEIGHT_W-1:0] weight_second,
    output logic signed [WEIGHT_W-1:0] weight_third,
    output logic                       degenerate
);

    coord_item_t   in_item;
    logic          front_ready;
    logic          front_valid;
    area_item_t    front_item;
    logic          mid_push;
    logic          mid_pop;
    area_item_t    mid_item;
    queue_status_t mid_status;
    logic          back_valid;
    weight_item_t  back_item;
    logic          out_push;
    weight_item_t  out_item;
    queue_status_t out_status;

    assign in_item.pnt    = {point_z, point_y, point_x};
    assign in_item.vtx[0] = {vertex0_z, vertex0_y, vertex0_x};
    assign in_item.vtx[1] = {vertex1_z, vertex1_y, vertex1_x};
    assign in_item.vtx[2] = {vertex2_z, vertex2_y, vertex2_x};

    assign full     = !front_ready;
    assign mid_push = front_valid && front_ready;
    assign out_push = back_valid && !out_status.full;

    sbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push && front_ready),
        .in_item   (in_item),
        .q_full    (mid_status.full),
        .ready     (front_ready),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    sbc_mid_queue u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_item (front_item),
        .rd_en   (mid_pop),
        .rd_item (mid_item),
        .status  (mid_status)
    );

    sbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!mid_status.empty),
        .in_item   (mid_item),
        .out_full  (out_status.full),
        .take      (mid_pop),
        .out_valid (back_valid),
        .out_item  (back_item)
    );

    sbc_out_queue u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_item (back_item),
        .rd_en   (pop && !out_status.empty),
        .rd_item (out_item),
        .status  (out_status)
    );

    assign empty         = out_status.empty;
    assign weight_first  = out_item.weight[0];
    assign weight_second = out_item.weight[1];
    assign weight_third  = out_item.weight[2];
    assign degenerate    = out_item.degen;

    a_full_only_on_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> mid_status.full)
        else $error("front stalled while mid queue had room");

    a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> !mid_status.full)
        else $error("mid queue written while full");

    a_mid_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> !mid_status.empty)
        else $error("mid queue read while empty");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && degenerate) |->
        (weight_first == '0 && weight_second == '0 && weight_third == '0))
        else $error("degenerate result with nonzero weight");

endmodule

FILE: tb/barycentric_checker.sv
`timescale 1ns / 1ps

module barycentric_checker
    import sbc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       full,
    input  logic [COORD_BITS-1:0]      point_x,
    input  logic [COORD_BITS-1:0]      point_y,
    input  logic [COORD_BITS-1:0]      point_z,
    input  logic [COORD_BITS-1:0]      vertex0_x,
    input  logic [COORD_BITS-1:0]      vertex0_y,
    input  logic [COORD_BITS-1:0]      vertex0_z,
    input  logic [COORD_BITS-1:0]      vertex1_x,
    input  logic [COORD_BITS-1:0]      vertex1_y,
    input  logic [COORD_BITS-1:0]      vertex1_z,
    input  logic [COORD_BITS-1:0]      vertex2_x,
    input  logic [COORD_BITS-1:0]      vertex2_y,
    input  logic [COORD_BITS-1:0]      vertex2_z,
    input  logic                       empty,
    input  logic                       pop,
    input  logic signed [WEIGHT_W-1:0] weight_first,
    input  logic signed [WEIGHT_W-1:0] weight_second,
    input  logic signed [WEIGHT_W-1:0] weight_third,
    input  logic                       degenerate,
    output int                         errors,
    output int                         pending
);

    typedef logic [191:0] wide_t;
    typedef logic signed [191:0] swide_t;

    weight_item_t expected_weights[$];

    function automatic longint coord_value(input logic [COORD_BITS-1:0] raw);
        logic signed [COORD_BITS-1:0] s;
        s = raw;
        return longint'(s);
    endfunction

    function automatic wide_t norm_sq(input longint x, input longint y, input longint z);
        wide_t ax;
        wide_t ay;
        wide_t az;
        ax = (x < 0) ? wide_t'(-x) : wide_t'(x);
        ay = (y < 0) ? wide_t'(-y) : wide_t'(y);
        az = (z < 0) ? wide_t'(-z) : wide_t'(z);
        return ax * ax + ay * ay + az * az;
    endfunction

    function automatic weight_item_t barycentric_weights(input logic [COORD_BITS-1:0] c[12]);
        weight_item_t r;
        longint p[3];
        longint v[3][3];
        longint f[3][3];
        longint e1[3];
        longint e2[3];
        longint a[3];
        longint b[3][3];
        wide_t den;
        wide_t num;
        wide_t lim;
        wide_t cand;
        wide_t m;
        swide_t dot;
        swide_t sa;
        swide_t sb;
        for (int k = 0; k < 3; k++)
        begin
            p[k] = coord_value(c[k]);
            for (int i = 0; i < 3; i++)
                v[i][k] = coord_value(c[3 + 3 * i + k]);
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
                f[i][k] = v[i][k] - p[k];
            e1[k] = v[0][k] - v[1][k];
            e2[k] = v[0][k] - v[2][k];
        end
        for (int k = 0; k < 3; k++)
        begin
            a[k] = e1[(k + 1) % 3] * e2[(k + 2) % 3] - e1[(k + 2) % 3] * e2[(k + 1) % 3];
            b[0][k] = f[1][(k + 1) % 3] * f[2][(k + 2) % 3]
                    - f[1][(k + 2) % 3] * f[2][(k + 1) % 3];
            b[1][k] = f[2][(k + 1) % 3] * f[0][(k + 2) % 3]
                    - f[2][(k + 2) % 3] * f[0][(k + 1) % 3];
            b[2][k] = f[0][(k + 1) % 3] * f[1][(k + 2) % 3]
                    - f[0][(k + 2) % 3] * f[1][(k + 1) % 3];
        end
        r = '0;
        den = norm_sq(a[0], a[1], a[2]);
        if (den == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            num = norm_sq(b[i][0], b[i][1], b[i][2]);
            lim = num << (2 * FRAC_BITS);
            m = 0;
            for (int bit_pos = 24; bit_pos >= 0; bit_pos--)
            begin
                cand = m | (wide_t'(1) << bit_pos);
                if (cand <= wide_t'(1 << 24) && cand * cand * den <= lim)
                    m = cand;
            end
            dot = 0;
            for (int k = 0; k < 3; k++)
            begin
                sa = a[k];
                sb = b[i][k];
                dot = dot + sa * sb;
            end
            if (dot < 0)
                r.weight[i] = WEIGHT_W'(-m);
            else
                r.weight[i] = (m > wide_t'((1 << 24) - 1)) ? WEIGHT_W'((1 << 24) - 1)
                                                           : WEIGHT_W'(m);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [COORD_BITS-1:0] c[12];
        weight_item_t want;
        int fails;
        fails = 0;
        if (!rst_n)
        begin
            expected_weights.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_weights.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    fails++;
                end
                else
                begin
                    want = expected_weights.pop_front();
                    if (weight_first !== $signed(want.weight[0]))
                    begin
                        $error("weight_first expected %0d actual %0d",
                               $signed(want.weight[0]), weight_first);
                        fails++;
                    end
                    if (weight_second !== $signed(want.weight[1]))
                    begin
                        $error("weight_second expected %0d actual %0d",
                               $signed(want.weight[1]), weight_second);
                        fails++;
                    end
                    if (weight_third !== $signed(want.weight[2]))
                    begin
                        $error("weight_third expected %0d actual %0d",
                               $signed(want.weight[2]), weight_third);
                        fails++;
                    end
                    if (degenerate !== want.degen)
                    begin
                        $error("degenerate expected %0d actual %0d", want.degen, degenerate);
                        fails++;
                    end
                end
            end
            if (push && !full)
            begin
                c = '{point_x, point_y, point_z, vertex0_x, vertex0_y, vertex0_z,
                      vertex1_x, vertex1_y, vertex1_z, vertex2_x, vertex2_y, vertex2_z};
                expected_weights.push_back(barycentric_weights(c));
            end
            errors  <= errors + fails;
            pending <= expected_weights.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sbc_pkg::*;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic empty;
    logic pop;
    logic [COORD_BITS-1:0] point_x, point_y, point_z;
    logic [COORD_BITS-1:0] vertex0_x, vertex0_y, vertex0_z;
    logic [COORD_BITS-1:0] vertex1_x, vertex1_y, vertex1_z;
    logic [COORD_BITS-1:0] vertex2_x, vertex2_y, vertex2_z;
    logic signed [WEIGHT_W-1:0] weight_first, weight_second, weight_third;
    logic degenerate;
    int errors;
    int pending;
    int tx_idle;
    int rx_idle;
    bit rx_hold_request;
    int cycle_count;
    logic [COORD_BITS-1:0] coords[12];

    signed_barycentric_3d_unit dut (.*);
    barycentric_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random pops, with a long hold-off on request
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                pop <= 1'b0;
            else if (rx_hold_request)
            begin
                pop <= 1'b0;
                repeat (300) @(posedge clk);
                rx_hold_request = 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic send_beat();
        point_x   <= coords[0];
        point_y   <= coords[1];
        point_z   <= coords[2];
        vertex0_x <= coords[3];
        vertex0_y <= coords[4];
        vertex0_z <= coords[5];
        vertex1_x <= coords[6];
        vertex1_y <= coords[7];
        vertex1_z <= coords[8];
        vertex2_x <= coords[9];
        vertex2_y <= coords[10];
        vertex2_z <= coords[11];
        push      <= 1'b1;
        do
            @(posedge clk);
        while (full);
        while ($urandom_range(99) < tx_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic set_all(input logic [COORD_BITS-1:0] val);
        for (int i = 0; i < 12; i++)
            coords[i] = val;
    endtask

    // point near a random center, vertices within span of it
    task automatic make_local(input int span, input int reach);
        int center[3];
        for (int k = 0; k < 3; k++)
            center[k] = $urandom_range(65535 - 2 * reach) - 32768 + reach;
        for (int k = 0; k < 3; k++)
            coords[k] = COORD_BITS'(center[k] + $urandom_range(2 * reach) - reach);
        for (int i = 1; i < 4; i++)
            for (int k = 0; k < 3; k++)
                coords[3 * i + k] = COORD_BITS'(center[k] + $urandom_range(2 * span) - span);
    endtask

    task automatic random_beat();
        int kind;
        kind = $urandom_range(99);
        if (kind < 15)
            for (int i = 0; i < 12; i++)
                coords[i] = COORD_BITS'($urandom);
        else if (kind < 25)
            make_local(1, 30000);
        else if (kind < 32)
        begin
            // third vertex takes each coordinate from vertex 0 or 1, so it can repeat one
            make_local(2000, 2000);
            for (int k = 0; k < 3; k++)
                coords[9 + k] = ($urandom_range(1)) ? coords[3 + k] : coords[6 + k];
        end
        else
            make_local(($urandom_range(3) == 0) ? 8 : 3000, ($urandom_range(1)) ? 100 : 6000);
        send_beat();
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        cycle_count = 0;
        rx_hold_request = 1'b0;
        tx_idle = 28;
        rx_idle = 59;
        set_all('0);
        point_x = '0; point_y = '0; point_z = '0;
        vertex0_x = '0; vertex0_y = '0; vertex0_z = '0;
        vertex1_x = '0; vertex1_y = '0; vertex1_z = '0;
        vertex2_x = '0; vertex2_y = '0; vertex2_z = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-area triangle
        set_all('0);
        send_beat();
        set_all(16'h8000);
        send_beat();
        set_all(16'h7fff);
        send_beat();
        // extremes: unit-ish big triangle, point at origin and at corners
        coords = '{16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
                   16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h7fff, 16'h7fff};
        send_beat();
        coords = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                   16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000};
        send_beat();
        coords = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                   16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000};
        send_beat();
        coords = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                   16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000};
        send_beat();
        // tiny triangle, far point: saturation both signs
        coords = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                   16'h8001, 16'h8000, 16'h8000, 16'h8000, 16'h8001, 16'h8000};
        send_beat();
        coords = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                   16'h8000, 16'h8001, 16'h8000, 16'h8001, 16'h8000, 16'h8000};
        send_beat();
        // collinear vertices
        coords = '{16'h0005, 16'h0003, 16'hfff0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0001, 16'h0001, 16'h0001, 16'h0002, 16'h0002, 16'h0002};
        send_beat();
        // point inside, outside, off the plane
        coords = '{16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                   16'h0004, 16'h0000, 16'h0000, 16'h0000, 16'h0004, 16'h0000};
        send_beat();
        coords = '{16'hfffb, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                   16'h0004, 16'h0000, 16'h0000, 16'h0000, 16'h0004, 16'h0000};
        send_beat();
        coords = '{16'h0001, 16'h0001, 16'h0009, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000, 16'h0004, 16'h0000, 16'h0004, 16'h0000, 16'h0000};
        send_beat();
        for (int i = 0; i < 6; i++)
            random_beat();

        // pause until drained
        push <= 1'b0;
        @(posedge clk);
        wait (pending == 0);

        for (int i = 0; i < 650; i++)
            random_beat();
        tx_idle = 59;
        rx_idle = 28;
        for (int i = 0; i < 650; i++)
            random_beat();
        tx_idle = 0;
        rx_idle = 0;
        rx_hold_request = 1'b1;
        for (int i = 0; i < 650; i++)
            random_beat();
        push <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: signed_barycentric_3d_unit.f
hdl/sbc_pkg.sv
hdl/sbc_front.sv
hdl/sbc_mid_queue.sv
hdl/sbc_back.sv
hdl/sbc_out_queue.sv
hdl/signed_barycentric_3d_unit.sv
tb/barycentric_checker.sv
tb/testbench.sv
